>>> rtl/sale_pkg.sv
`default_nettype none
package sale_pkg;

    // List capacity; the index and count widths follow from it.
    localparam int DEPTH = 64;
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int POS_W = 6;
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
    localparam int DATA_W = 32;

    // Request codes.
    localparam logic [3:0] ACT_INS_SORTED = 4'd0;
    localparam logic [3:0] ACT_INS_FRONT  = 4'd1;
    localparam logic [3:0] ACT_INS_END    = 4'd2;
    localparam logic [3:0] ACT_INS_POS    = 4'd3;
    localparam logic [3:0] ACT_BSEARCH    = 4'd4;
    localparam logic [3:0] ACT_LSEARCH    = 4'd5;
    localparam logic [3:0] ACT_DEL_VALUE  = 4'd6;
    localparam logic [3:0] ACT_DEL_POS    = 4'd7;
    localparam logic [3:0] ACT_SORT       = 4'd8;
    localparam logic [3:0] ACT_CLEAR      = 4'd9;

    // Status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_MISS  = 3'd4;

endpackage
`default_nettype wire

>>> rtl/sorted_array_list_engine.sv
// Channel  | Direction | Signals                          | Beat
// request  | in        | s_tvalid s_tready s_tdata s_tuser | action, value, position
// result   | out       | m_tvalid m_tready m_tdata         | status, found, index, count
//
// One request is processed at a time. Every element step reads the entry memory
// in a read state and uses the data in a check or write state, so the work of a
// linear search or a shift grows with count, a binary search with log2(count),
// and a sort with count*count. A clear, a sort of fewer than two entries, an
// insert into a full list, a delete at an out-of-range position and an unused
// code are answered from the idle state; a duplicate or an out-of-range insert
// position is only known after the duplicate scan.
// Reset empties the list at once; the entries need no clearing pass.
// The result waits in an output register; a new request is taken once it has
// been delivered.
`default_nettype none
module sorted_array_list_engine
    import sale_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // value[31:0], position[37:32], zero fill
    input  wire logic [3:0]  s_tuser,   // action[3:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata    // status[2:0], found[3], index[9:4], count[16:10]
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_SCAN_RD  = 14'b00000000000010,
        S_SCAN_CHK = 14'b00000000000100,
        S_BIN_RD   = 14'b00000000001000,
        S_BIN_CHK  = 14'b00000000010000,
        S_SHR_RD   = 14'b00000000100000,
        S_SHR_WR   = 14'b00000001000000,
        S_SHL_RD   = 14'b00000010000000,
        S_SHL_WR   = 14'b00000100000000,
        S_SRT_LD   = 14'b00001000000000,
        S_SRT_CAR  = 14'b00010000000000,
        S_SRT_RD   = 14'b00100000000000,
        S_SRT_CHK  = 14'b01000000000000,
        S_SRT_END  = 14'b10000000000000
    } state_t;

    typedef logic signed [CW:0] bound_t;

    state_t              state_reg, state_next;
    logic [3:0]          act_reg, act_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       at_reg, at_next;
    logic [CW-1:0]       lim_reg, lim_next;
    bound_t              lo_reg, lo_next;
    bound_t              hi_reg, hi_next;
    logic [DATA_W-1:0]   carry_reg, carry_next;
    logic [2:0]          status_reg, status_next;
    logic                found_reg, found_next;
    logic [IW-1:0]       index_reg, index_next;
    logic                out_valid_reg, out_valid_next;

    logic                we;
    logic [IW-1:0]       waddr;
    logic [DATA_W-1:0]   wdata;
    logic [IW-1:0]       raddr;
    logic [DATA_W-1:0]   rdata;

    logic                in_fire;
    logic [CW:0]         bin_sum;
    logic [CW-1:0]       mid;
    logic                e_eq;
    logic                e_lt;
    logic                pos_ok;

    sale_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, 7'(cnt_reg), 6'(index_reg), found_reg, status_reg};

    // Midpoint of the current binary search window; both bounds are
    // non-negative whenever a probe is issued.
    assign bin_sum = lo_reg + hi_reg;
    assign mid     = bin_sum[CW:1];

    assign e_eq   = (rdata == val_reg);
    assign e_lt   = $signed(rdata) < $signed(val_reg);
    assign pos_ok = CMP_W'(pos_reg) < CMP_W'(cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        at_next        = at_reg;
        lim_next       = lim_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        carry_next     = carry_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        index_next     = index_reg;
        out_valid_next = out_valid_reg;
        we             = 1'b0;
        waddr          = ptr_reg[IW-1:0];
        wdata          = rdata;
        raddr          = ptr_reg[IW-1:0];

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    act_next    = s_tuser;
                    val_next    = s_tdata[31:0];
                    pos_next    = s_tdata[37:32];
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    index_next  = '0;
                    ptr_next    = '0;
                    case (s_tuser)
                        ACT_INS_SORTED, ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS:
                        begin
                            if (cnt_reg == CW'(DEPTH))
                            begin
                                status_next    = ST_FULL;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        ACT_LSEARCH:
                        begin
                            state_next = S_SCAN_RD;
                        end
                        ACT_BSEARCH, ACT_DEL_VALUE:
                        begin
                            lo_next    = '0;
                            hi_next    = $signed({1'b0, cnt_reg}) - bound_t'(1);
                            state_next = S_BIN_RD;
                        end
                        ACT_DEL_POS:
                        begin
                            if (CMP_W'(s_tdata[37:32]) >= CMP_W'(cnt_reg))
                            begin
                                status_next    = ST_RANGE;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = CW'(s_tdata[37:32]);
                                index_next = IW'(s_tdata[37:32]);
                                state_next = S_SHL_RD;
                            end
                        end
                        ACT_SORT:
                        begin
                            if (cnt_reg < CW'(2))
                            begin
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                lim_next   = cnt_reg - CW'(1);
                                state_next = S_SRT_LD;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            cnt_next       = '0;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            status_next    = ST_RANGE;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                if (ptr_reg >= cnt_reg)
                begin
                    // The scan ran off the end without a match.
                    case (act_reg)
                        ACT_INS_SORTED, ACT_INS_END:
                        begin
                            at_next    = cnt_reg;
                            index_next = cnt_reg[IW-1:0];
                            ptr_next   = cnt_reg;
                            state_next = S_SHR_RD;
                        end
                        ACT_INS_FRONT:
                        begin
                            at_next    = '0;
                            index_next = '0;
                            ptr_next   = cnt_reg;
                            state_next = S_SHR_RD;
                        end
                        ACT_INS_POS:
                        begin
                            if (pos_ok)
                            begin
                                at_next    = CW'(pos_reg);
                                index_next = IW'(pos_reg);
                                ptr_next   = cnt_reg;
                                state_next = S_SHR_RD;
                            end
                            else
                            begin
                                status_next    = ST_RANGE;
                                out_valid_next = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end
                        default:
                        begin
                            status_next    = ST_MISS;
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (act_reg == ACT_INS_SORTED)
                begin
                    if (!e_lt)
                    begin
                        index_next = ptr_reg[IW-1:0];
                        if (e_eq)
                        begin
                            status_next    = ST_DUP;
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            at_next    = ptr_reg;
                            ptr_next   = cnt_reg;
                            state_next = S_SHR_RD;
                        end
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + CW'(1);
                        state_next = S_SCAN_RD;
                    end
                end
                else if (e_eq)
                begin
                    index_next     = ptr_reg[IW-1:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (act_reg == ACT_LSEARCH)
                    begin
                        found_next = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_DUP;
                    end
                end
                else
                begin
                    ptr_next   = ptr_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_BIN_RD:
            begin
                if (lo_reg <= hi_reg)
                begin
                    raddr      = mid[IW-1:0];
                    ptr_next   = mid;
                    state_next = S_BIN_CHK;
                end
                else
                begin
                    status_next    = ST_MISS;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_BIN_CHK:
            begin
                if (e_eq)
                begin
                    found_next = 1'b1;
                    index_next = ptr_reg[IW-1:0];
                    if (act_reg == ACT_DEL_VALUE)
                    begin
                        state_next = S_SHL_RD;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (e_lt)
                begin
                    lo_next    = $signed({1'b0, ptr_reg}) + bound_t'(1);
                    state_next = S_BIN_RD;
                end
                else
                begin
                    hi_next    = $signed({1'b0, ptr_reg}) - bound_t'(1);
                    state_next = S_BIN_RD;
                end
            end

            S_SHR_RD:
            begin
                if (ptr_reg > at_reg)
                begin
                    raddr      = ptr_reg[IW-1:0] - IW'(1);
                    state_next = S_SHR_WR;
                end
                else
                begin
                    we             = 1'b1;
                    waddr          = at_reg[IW-1:0];
                    wdata          = val_reg;
                    cnt_next       = cnt_reg + CW'(1);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_SHR_WR:
            begin
                we         = 1'b1;
                ptr_next   = ptr_reg - CW'(1);
                state_next = S_SHR_RD;
            end

            S_SHL_RD:
            begin
                if ((ptr_reg + CW'(1)) < cnt_reg)
                begin
                    raddr      = ptr_reg[IW-1:0] + IW'(1);
                    state_next = S_SHL_WR;
                end
                else
                begin
                    cnt_next       = cnt_reg - CW'(1);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_SHL_WR:
            begin
                we         = 1'b1;
                ptr_next   = ptr_reg + CW'(1);
                state_next = S_SHL_RD;
            end

            S_SRT_LD:
            begin
                raddr      = '0;
                ptr_next   = '0;
                state_next = S_SRT_CAR;
            end

            S_SRT_CAR:
            begin
                carry_next = rdata;
                raddr      = ptr_reg[IW-1:0] + IW'(1);
                state_next = S_SRT_CHK;
            end

            S_SRT_RD:
            begin
                raddr      = ptr_reg[IW-1:0] + IW'(1);
                state_next = S_SRT_CHK;
            end

            S_SRT_CHK:
            begin
                // The larger of the pair moves on in the carry register.
                we = 1'b1;
                if ($signed(rdata) < $signed(carry_reg))
                begin
                    wdata = rdata;
                end
                else
                begin
                    wdata      = carry_reg;
                    carry_next = rdata;
                end
                ptr_next = ptr_reg + CW'(1);
                if ((ptr_reg + CW'(1)) < lim_reg)
                begin
                    state_next = S_SRT_RD;
                end
                else
                begin
                    state_next = S_SRT_END;
                end
            end

            S_SRT_END:
            begin
                we    = 1'b1;
                waddr = lim_reg[IW-1:0];
                wdata = carry_reg;
                if (lim_reg == CW'(1))
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    lim_next   = lim_reg - CW'(1);
                    state_next = S_SRT_LD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        val_reg    <= val_next;
        pos_reg    <= pos_next;
        ptr_reg    <= ptr_next;
        at_reg     <= at_next;
        lim_reg    <= lim_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        carry_reg  <= carry_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        index_reg  <= index_next;
    end

    // The element count never exceeds the capacity.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("element count above capacity");

    // No new request is taken while a result is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("request accepted while result pending");

    // The memory is never written from the idle state.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg != S_IDLE))
        else $error("memory write while idle");

    // An accepted request always leaves the idle-ready condition next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("ready held after accept");

endmodule
`default_nettype wire

>>> rtl/sale_ram.sv
`default_nettype none
module sale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> dv/tb_sorted_array_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_array_list_engine;
    import sale_pkg::*;

    // One request beat as the stimulus builds it.
    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] value;
        logic [5:0]  position;
    } request_t;

    // One result beat, laid out as the low bits of m_tdata.
    typedef struct packed {
        logic [6:0] count;
        logic [5:0] index;
        logic       found;
        logic [2:0] status;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    request_t pending_requests[$];
    result_t  expected_results[$];

    // Shadow copy of the list that the predictor keeps in step with the block.
    logic [31:0] shadow_list[DEPTH];
    int          shadow_count;

    int  failures;
    int  requests_sent;
    int  results_checked;
    int  action_hits[16];
    int  status_hits[8];
    // While set, both sides stop idling so the block runs back to back.
    bit  busy_stretch;

    sorted_array_list_engine i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Signed compare of two raw list words.
    function automatic bit signed_less(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic int scan_for(logic [31:0] v);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_list[i] == v)
                return i;
        return -1;
    endfunction

    // Binary probe over the list as stored, sorted or not.
    function automatic int probe_for(logic [31:0] v);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = shadow_count - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_list[mid] == v)
                return mid;
            if (signed_less(shadow_list[mid], v))
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return -1;
    endfunction

    function automatic void open_at(int at, logic [31:0] v);
        for (int i = shadow_count; i > at; i--)
            shadow_list[i] = shadow_list[i - 1];
        shadow_list[at] = v;
        shadow_count++;
    endfunction

    function automatic void close_at(int at);
        for (int i = at; i + 1 < shadow_count; i++)
            shadow_list[i] = shadow_list[i + 1];
        shadow_count--;
    endfunction

    // Applies one request to the shadow list and returns the result it must produce.
    function automatic result_t apply_request(request_t r);
        result_t res;
        int      hit;
        int      p;
        logic [31:0] t;
        res = '0;
        res.status = ST_OK;
        case (r.action)
            ACT_INS_SORTED: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    p = 0;
                    while (p < shadow_count && signed_less(shadow_list[p], r.value))
                        p++;
                    if (p < shadow_count && shadow_list[p] == r.value) begin
                        res.status = ST_DUP;
                        res.index = p[5:0];
                    end else begin
                        open_at(p, r.value);
                        res.index = p[5:0];
                    end
                end
            end
            ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS: begin
                hit = scan_for(r.value);
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (hit >= 0) begin
                    res.status = ST_DUP;
                    res.index = hit[5:0];
                end else if (r.action == ACT_INS_FRONT) begin
                    open_at(0, r.value);
                end else if (r.action == ACT_INS_END) begin
                    res.index = shadow_count[5:0];
                    shadow_list[shadow_count] = r.value;
                    shadow_count++;
                end else if (int'(r.position) >= shadow_count) begin
                    res.status = ST_RANGE;
                end else begin
                    open_at(r.position, r.value);
                    res.index = r.position;
                end
            end
            ACT_BSEARCH, ACT_LSEARCH, ACT_DEL_VALUE: begin
                hit = (r.action == ACT_LSEARCH) ? scan_for(r.value) : probe_for(r.value);
                if (hit < 0) begin
                    res.status = ST_MISS;
                end else begin
                    res.found = 1'b1;
                    res.index = hit[5:0];
                    if (r.action == ACT_DEL_VALUE)
                        close_at(hit);
                end
            end
            ACT_DEL_POS: begin
                if (int'(r.position) >= shadow_count) begin
                    res.status = ST_RANGE;
                end else begin
                    close_at(r.position);
                    res.index = r.position;
                end
            end
            ACT_SORT: begin
                for (int pass = 0; pass + 1 < shadow_count; pass++)
                    for (int j = 0; j + 1 < shadow_count - pass; j++)
                        if (signed_less(shadow_list[j + 1], shadow_list[j])) begin
                            t = shadow_list[j];
                            shadow_list[j] = shadow_list[j + 1];
                            shadow_list[j + 1] = t;
                        end
            end
            ACT_CLEAR: shadow_count = 0;
            default: res.status = ST_RANGE;
        endcase
        res.count = shadow_count[6:0];
        return res;
    endfunction

    function automatic request_t make_request(logic [3:0] a, logic [31:0] v, logic [5:0] p);
        request_t r;
        r.action = a;
        r.value = v;
        r.position = p;
        return r;
    endfunction

    // Values come from a narrow pool most of the time so that duplicates, hits
    // and deletes happen often; the rest are full-range words.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 32'($signed($urandom_range(0, 80)) - 40);
            6: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Mostly valid actions; codes above clear are rare noise. Clear is kept
    // rare so the list regularly grows to full.
    function automatic logic [3:0] pick_action();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return ACT_INS_SORTED;
        if (roll < 38) return ACT_INS_FRONT;
        if (roll < 46) return ACT_INS_END;
        if (roll < 54) return ACT_INS_POS;
        if (roll < 64) return ACT_BSEARCH;
        if (roll < 72) return ACT_LSEARCH;
        if (roll < 82) return ACT_DEL_VALUE;
        if (roll < 90) return ACT_DEL_POS;
        if (roll < 94) return ACT_SORT;
        if (roll < 96) return ACT_CLEAR;
        return 4'($urandom_range(10, 15));
    endfunction

    // Driver: presents the next pending request and holds it until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            // The previous beat, if any, was just taken.
            if (pending_requests.size() > 0 &&
                (busy_stretch || $urandom_range(0, 99) >= 16))
            begin
                request_t r;
                r = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, r.position, r.value};
                s_tuser  <= r.action;
                expected_results.push_back(apply_request(r));
                action_hits[r.action]++;
                requests_sent++;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each delivered result against the oldest expectation
    // and randomly throttles the result side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_t got;
                result_t want;
                got = m_tdata[16:0];
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: %h", m_tdata);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    status_hits[got.status]++;
                    results_checked++;
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        failures++;
                    end
                    if (got.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, got.found);
                        failures++;
                    end
                    if (got.index !== want.index)
                    begin
                        $error("index: expected %0d, got %0d", want.index, got.index);
                        failures++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        failures++;
                    end
                end
            end
            m_tready <= busy_stretch || ($urandom_range(0, 99) >= 16);
        end
    end

    initial
    begin
        int          target;
        logic [31:0] v;
        rst_n = 1'b0;
        failures = 0;
        requests_sent = 0;
        results_checked = 0;
        busy_stretch = 1'b0;
        shadow_count = 0;

        // Directed opening: empty-list range errors and misses, the value
        // extremes, a duplicate on the sorted, front and position insert kinds,
        // an unsorted list under binary search, a sort, unused codes and a clear.
        pending_requests.push_back(make_request(ACT_INS_POS, 32'd5, 6'd0));
        pending_requests.push_back(make_request(ACT_DEL_POS, 32'd0, 6'd63));
        pending_requests.push_back(make_request(ACT_BSEARCH, 32'd1, 6'd0));
        pending_requests.push_back(make_request(ACT_DEL_VALUE, 32'd1, 6'd0));
        pending_requests.push_back(make_request(ACT_SORT, 32'd0, 6'd0));
        pending_requests.push_back(make_request(ACT_INS_END, 32'h7fff_ffff, 6'd0));
        pending_requests.push_back(make_request(ACT_INS_FRONT, 32'h8000_0000, 6'd0));
        pending_requests.push_back(make_request(ACT_INS_END, 32'hffff_ffff, 6'd0));
        pending_requests.push_back(make_request(ACT_INS_POS, 32'd0, 6'd1));
        pending_requests.push_back(make_request(ACT_INS_SORTED, 32'h7fff_ffff, 6'd0));
        pending_requests.push_back(make_request(ACT_INS_FRONT, 32'hffff_ffff, 6'd0));
        pending_requests.push_back(make_request(ACT_INS_POS, 32'd0, 6'd63));
        pending_requests.push_back(make_request(ACT_BSEARCH, 32'd0, 6'd0));
        pending_requests.push_back(make_request(ACT_LSEARCH, 32'hffff_ffff, 6'd0));
        pending_requests.push_back(make_request(ACT_SORT, 32'd0, 6'd0));
        pending_requests.push_back(make_request(ACT_BSEARCH, 32'h8000_0000, 6'd0));
        pending_requests.push_back(make_request(ACT_DEL_VALUE, 32'h7fff_ffff, 6'd0));
        pending_requests.push_back(make_request(ACT_DEL_POS, 32'd0, 6'd1));
        pending_requests.push_back(make_request(4'd10, 32'd0, 6'd0));
        pending_requests.push_back(make_request(4'd15, 32'hffff_ffff, 6'h3f));
        pending_requests.push_back(make_request(ACT_CLEAR, 32'd0, 6'd0));

        // Fill the list completely, then hit it with every insert kind.
        for (int i = 0; i < DEPTH; i++)
            pending_requests.push_back(make_request(ACT_INS_END, 32'(i * 3 - 90), 6'd0));
        pending_requests.push_back(make_request(ACT_INS_SORTED, 32'd1, 6'd0));
        pending_requests.push_back(make_request(ACT_INS_FRONT, 32'd1, 6'd0));
        pending_requests.push_back(make_request(ACT_INS_END, 32'd1, 6'd0));
        pending_requests.push_back(make_request(ACT_INS_POS, 32'd1, 6'd63));
        pending_requests.push_back(make_request(ACT_DEL_POS, 32'd0, 6'd63));
        pending_requests.push_back(make_request(ACT_BSEARCH, 32'd93, 6'd0));

        // Random part: the position field is mostly near the live range.
        target = 1860;
        for (int i = 0; i < target; i++)
        begin
            v = pick_value();
            pending_requests.push_back(make_request(pick_action(), v,
                6'($urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 20))));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // A stretch of back-to-back traffic in the middle of the run.
        wait (requests_sent > 900);
        busy_stretch = 1'b1;
        wait (requests_sent > 1200);
        busy_stretch = 1'b0;

        wait (pending_requests.size() == 0 && expected_results.size() == 0);
        repeat (20) @(posedge clk);

        $display("Checked %0d results from %0d requests; statuses ok/dup/full/range/miss:",
                 results_checked, requests_sent);
        $display("  %0d/%0d/%0d/%0d/%0d, sorts %0d, clears %0d", status_hits[0],
                 status_hits[1], status_hits[2], status_hits[3], status_hits[4],
                 action_hits[ACT_SORT], action_hits[ACT_CLEAR]);
        if (failures == 0 && expected_results.size() == 0)
            $display("[sorted_array_list_engine] OK");
        else
            $display("[sorted_array_list_engine] ERROR");
        $finish;
    end

    // Watchdog: a sort of a full list is the slowest request there is; even if
    // all 1951 requests were such sorts under heavy stalls, the run would stay
    // well within this bound.
    initial
    begin
        #500ms;
        $display("[sorted_array_list_engine] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
